// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the pixel effect modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define RPCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpce assertion failed");

// Next-cycle implication, masked while reset is high.
`define RPCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpce assertion failed");

`endif

// ===== rtl/core/rpce_pkg.sv =====
`default_nettype none

package rpce_pkg;

  // Channel and arithmetic widths
  localparam int CHANNEL_BITS   = 8;
  localparam int MAX_BITS       = 8;
  localparam int COEF_BITS      = 16;
  localparam int FRAC_BITS      = 16;
  localparam int PROD_BITS      = COEF_BITS + CHANNEL_BITS;
  localparam int ACC_BITS       = PROD_BITS + 2;
  localparam int SUM_BITS       = CHANNEL_BITS + 2;
  localparam int RECIP_SHIFT    = SUM_BITS;
  localparam int RECIP_THIRD    = (1 << RECIP_SHIFT) / 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [COEF_BITS-1:0]    coef_t;

  localparam chan_t CH_FULL = '1;

  typedef enum logic [1:0] {
    MODE_NEGATIVE = 2'd0,
    MODE_GRAY     = 2'd1,
    MODE_SEPIA    = 2'd2,
    MODE_XRAY     = 2'd3
  } effect_mode_t;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_VALUE   = 2'd1;
  localparam effect_mode_t              EFFECT_MODE_RESET = MODE_GRAY;
  localparam logic [MAX_BITS-1:0]       MAX_VALUE_RESET   = 8'd255;

  // Q16 coefficients, row k gives output channel k
  localparam coef_t SEPIA_Q16 [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };
  localparam coef_t LUMA_Q16 [3] = '{16'd19595, 16'd38470, 16'd7471};

  // Beat leaving the multiply stage
  typedef struct packed {
    effect_mode_t                     mode;
    logic                             eoi;
    logic [2:0][CHANNEL_BITS-1:0]     neg;
    logic [SUM_BITS-1:0]              sum;
    logic [2:0][2:0][PROD_BITS-1:0]   sepia_prod;
    logic [2:0][PROD_BITS-1:0]        luma_prod;
  } mult_beat_t;

  // Beat leaving the accumulate stage
  typedef struct packed {
    effect_mode_t                     mode;
    logic                             eoi;
    logic [2:0][CHANNEL_BITS-1:0]     neg;
    logic [SUM_BITS-1:0]              sum;
    logic [SUM_BITS-1:0]              quot_est;
    logic [2:0][ACC_BITS-1:0]         sepia_acc;
    logic [ACC_BITS-1:0]              luma_acc;
  } accum_beat_t;

  // Finished pixel
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  eoi;
  } pixel_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpce_mult.sv =====
`default_nettype none

module rpce_mult
  import rpce_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire chan_t               red,
  input  wire chan_t               green,
  input  wire chan_t               blue,
  input  wire logic                eoi,
  input  wire effect_mode_t        mode,
  input  wire logic [MAX_BITS-1:0] max_value,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output mult_beat_t               dn_beat
);

  mult_beat_t beat_next;
  chan_t      ch [3];
  chan_t      max_ext;

  assign ch[0]   = red;
  assign ch[1]   = green;
  assign ch[2]   = blue;
  assign max_ext = CHANNEL_BITS'(max_value);

  // Form all products, the channel sum and the negative values
  always_comb begin
    beat_next.mode = mode;
    beat_next.eoi  = eoi;
    beat_next.sum  = SUM_BITS'(red) + SUM_BITS'(green) + SUM_BITS'(blue);
    for (int k = 0; k < 3; k++) begin
      beat_next.neg[k] = (ch[k] > max_ext) ? '0 : max_ext - ch[k];
      beat_next.luma_prod[k] = PROD_BITS'(LUMA_Q16[k]) * PROD_BITS'(ch[k]);
      for (int j = 0; j < 3; j++) begin
        beat_next.sepia_prod[k][j] = PROD_BITS'(SEPIA_Q16[k][j]) * PROD_BITS'(ch[j]);
      end
    end
  end

  // Advance when the stage is empty or its beat is being taken
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpce_accum.sv =====
`default_nettype none

module rpce_accum
  import rpce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire mult_beat_t  up_beat,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output accum_beat_t      dn_beat
);

  accum_beat_t               beat_next;
  logic [2*SUM_BITS-1:0]     recip_prod;

  // Estimate sum / 3 by a reciprocal multiply; low by at most one
  assign recip_prod = (2*SUM_BITS)'(up_beat.sum) * (2*SUM_BITS)'(RECIP_THIRD);

  // Add up the matrix rows and the luma terms
  always_comb begin
    beat_next.mode     = up_beat.mode;
    beat_next.eoi      = up_beat.eoi;
    beat_next.neg      = up_beat.neg;
    beat_next.sum      = up_beat.sum;
    beat_next.quot_est = recip_prod[2*SUM_BITS-1:RECIP_SHIFT];
    for (int k = 0; k < 3; k++) begin
      beat_next.sepia_acc[k] = ACC_BITS'(up_beat.sepia_prod[k][0])
                             + ACC_BITS'(up_beat.sepia_prod[k][1])
                             + ACC_BITS'(up_beat.sepia_prod[k][2]);
    end
    beat_next.luma_acc = ACC_BITS'(up_beat.luma_prod[0])
                       + ACC_BITS'(up_beat.luma_prod[1])
                       + ACC_BITS'(up_beat.luma_prod[2]);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpce_select.sv =====
`default_nettype none

`include "assert_macros.svh"

module rpce_select
  import rpce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire accum_beat_t up_beat,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output pixel_t           dn_pixel
);

  pixel_t                     pixel_next;
  logic [SUM_BITS-1:0]        rem;
  logic [SUM_BITS-1:0]        quot;
  chan_t                      avg;
  chan_t                      xray;
  chan_t                      sepia [3];
  logic [ACC_BITS-FRAC_BITS-1:0] luma;
  logic [ACC_BITS-FRAC_BITS-1:0] sepia_int [3];

  // Correct the quotient estimate with one compare and add
  assign rem  = up_beat.sum - ((up_beat.quot_est << 1) + up_beat.quot_est);
  assign quot = (rem >= SUM_BITS'(3)) ? up_beat.quot_est + SUM_BITS'(1) : up_beat.quot_est;
  assign avg  = quot[CHANNEL_BITS-1:0];

  // Drop the fraction, then invert against full scale, giving zero above it
  assign luma = up_beat.luma_acc[ACC_BITS-1:FRAC_BITS];
  assign xray = (luma > (ACC_BITS-FRAC_BITS)'(CH_FULL)) ? '0
              : CH_FULL - luma[CHANNEL_BITS-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sepia_int[k] = up_beat.sepia_acc[k][ACC_BITS-1:FRAC_BITS];
      sepia[k] = (sepia_int[k] > (ACC_BITS-FRAC_BITS)'(CH_FULL)) ? CH_FULL
               : sepia_int[k][CHANNEL_BITS-1:0];
    end
  end

  // Pick the effect
  always_comb begin
    pixel_next.eoi = up_beat.eoi;
    case (up_beat.mode)
      MODE_NEGATIVE: begin
        pixel_next.red   = up_beat.neg[0];
        pixel_next.green = up_beat.neg[1];
        pixel_next.blue  = up_beat.neg[2];
      end
      MODE_GRAY: begin
        pixel_next.red   = avg;
        pixel_next.green = avg;
        pixel_next.blue  = avg;
      end
      MODE_SEPIA: begin
        pixel_next.red   = sepia[0];
        pixel_next.green = sepia[1];
        pixel_next.blue  = sepia[2];
      end
      default: begin
        pixel_next.red   = xray;
        pixel_next.green = xray;
        pixel_next.blue  = xray;
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  // Output register: hold the pixel while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_pixel <= pixel_next;
    end
  end

  `RPCE_ASSERT_IMPL(a_quot_corr_range, clk, rst, up_valid, rem < SUM_BITS'(6))
  `RPCE_ASSERT_IMPL(a_mono_modes, clk, rst, up_valid && (up_beat.mode == MODE_GRAY || up_beat.mode == MODE_XRAY), pixel_next.red == pixel_next.green && pixel_next.green == pixel_next.blue)
  `RPCE_ASSERT_NEXT(a_out_load, clk, rst, up_valid && up_ready, dn_valid && dn_pixel == $past(pixel_next))

endmodule

`default_nettype wire

// ===== rtl/core/rgb_pixel_color_effects.sv =====
// RGB pixel colour effects.
// Input channel: in_valid/in_ready with red_in, green_in, blue_in and
// end_of_image, one pixel per beat. Output channel: out_valid/out_ready with
// red_out, green_out, blue_out and end_of_image_out, one pixel per input beat,
// in order. Configuration channel: cfg_valid/cfg_ready with cfg_index and
// cfg_data; index 0 is effect_mode (0 negative, 1 grayscale average, 2 sepia,
// 3 x-ray), index 1 is max_value for the negative effect. Other indexes are
// ignored. cfg_ready is always high; write only while the pipeline is empty.
// Path: an accepted beat is registered in the multiply stage, then in the
// accumulate stage, then in the select stage that presents it on the output.
// Throughput: one pixel per cycle while out_ready is high, set by three register
// stages (multiply, row accumulate, clamp and select), each advancing on its own
// valid bit. Reset: empties the pipeline, effect_mode returns to grayscale and
// max_value to 255. When out_ready is low the output beat holds and the stages
// fill behind it; in_ready falls once all three hold a pixel. Nothing is lost.
`default_nettype none

`include "assert_macros.svh"

module rgb_pixel_color_effects
  import rpce_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire chan_t                     red_in,
  input  wire chan_t                     green_in,
  input  wire chan_t                     blue_in,
  input  wire logic                      end_of_image,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output chan_t                          red_out,
  output chan_t                          green_out,
  output chan_t                          blue_out,
  output logic                           end_of_image_out
);

  effect_mode_t          effect_mode;
  logic [MAX_BITS-1:0]   max_value;

  logic                  m_valid;
  logic                  m_ready;
  mult_beat_t            m_beat;
  logic                  a_valid;
  logic                  a_ready;
  accum_beat_t           a_beat;
  pixel_t                pixel;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= EFFECT_MODE_RESET;
      max_value   <= MAX_VALUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EFFECT_MODE: effect_mode <= effect_mode_t'(cfg_data[1:0]);
        CFG_MAX_VALUE:   max_value   <= cfg_data[MAX_BITS-1:0];
        default: ;
      endcase
    end
  end

  rpce_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .red       (red_in),
    .green     (green_in),
    .blue      (blue_in),
    .eoi       (end_of_image),
    .mode      (effect_mode),
    .max_value (max_value),
    .dn_valid  (m_valid),
    .dn_ready  (m_ready),
    .dn_beat   (m_beat)
  );

  rpce_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (m_valid),
    .up_ready (m_ready),
    .up_beat  (m_beat),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_beat  (a_beat)
  );

  rpce_select u_select (
    .clk      (clk),
    .rst      (rst),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_beat  (a_beat),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_pixel (pixel)
  );

  assign red_out          = pixel.red;
  assign green_out        = pixel.green;
  assign blue_out         = pixel.blue;
  assign end_of_image_out = pixel.eoi;

  `RPCE_ASSERT_IMPL(a_cfg_after_reset, clk, rst, $past(rst), effect_mode == EFFECT_MODE_RESET && max_value == MAX_VALUE_RESET)
  `RPCE_ASSERT_IMPL(a_full_pipe_stalls, clk, rst, out_valid && !out_ready && a_valid && m_valid, !in_ready)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top
  import rpce_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 12;
  localparam int PIPE_LATENCY     = 3;
  localparam int SINK_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int REPORT_LIMIT     = 10;
  localparam int RANDOM_PHASES    = 12;
  localparam int PHASE_PIXELS     = 92;
  localparam int STALL_PIXELS     = 40;

  // Indexes with no register behind them
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_HI = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic in_valid;
  logic in_ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  logic end_of_image;
  logic out_valid;
  logic out_ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic end_of_image_out;

  // Mirror of the effect registers and the pixels still owed by the block
  effect_mode_t mode_mirror;
  chan_t        max_mirror;
  pixel_t       pending_pixels[$];
  int           mismatches;
  bit           tx_idle_on;
  bit           rx_idle_on;
  bit           sink_hold_req;

  rgb_pixel_color_effects dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .red_in           (red_in),
    .green_in         (green_in),
    .blue_in          (blue_in),
    .end_of_image     (end_of_image),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .red_out          (red_out),
    .green_out        (green_out),
    .blue_out         (blue_out),
    .end_of_image_out (end_of_image_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic chan_t clamp_chan(input int unsigned v);
    return (v > 255) ? 8'hFF : chan_t'(v);
  endfunction

  // Work out the processed pixel for the current register settings
  function automatic pixel_t apply_effect(input effect_mode_t mode, input chan_t limit,
                                          input chan_t r, input chan_t g, input chan_t b,
                                          input logic eoi);
    pixel_t px;
    int unsigned luma;
    px.eoi = eoi;
    case (mode)
      MODE_NEGATIVE: begin
        px.red   = (r > limit) ? 8'd0 : chan_t'(limit - r);
        px.green = (g > limit) ? 8'd0 : chan_t'(limit - g);
        px.blue  = (b > limit) ? 8'd0 : chan_t'(limit - b);
      end
      MODE_GRAY: begin
        px.red   = chan_t'((int'(r) + int'(g) + int'(b)) / 3);
        px.green = px.red;
        px.blue  = px.red;
      end
      MODE_SEPIA: begin
        px.red   = clamp_chan((25756 * r + 50397 * g + 12386 * b) >> 16);
        px.green = clamp_chan((22872 * r + 44958 * g + 11010 * b) >> 16);
        px.blue  = clamp_chan((17826 * r + 34996 * g + 8585 * b) >> 16);
      end
      default: begin
        luma     = (19595 * r + 38470 * g + 7471 * b) >> 16;
        px.red   = (luma > 255) ? 8'd0 : chan_t'(255 - luma);
        px.green = px.red;
        px.blue  = px.red;
      end
    endcase
    return px;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bias towards the edges and the negative threshold
  function automatic chan_t rand_chan();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 8'h00;
    if (roll < 16) return 8'hFF;
    if (roll < 24) return chan_t'(max_mirror + $urandom_range(0, 2) - 1);
    return chan_t'($urandom_range(0, 255));
  endfunction

  // Offer one pixel beat, hold it until taken, then log the expected pixel
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic eoi);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    end_of_image <= eoi;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(apply_effect(mode_mirror, max_mirror, r, g, b, eoi));
  endtask

  // Write one register and update the mirror
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EFFECT_MODE: mode_mirror = effect_mode_t'(data[1:0]);
      CFG_MAX_VALUE:   max_mirror  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every owed pixel, plus the pipeline depth
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Registers untouched since reset: grayscale, edges and rounding
  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'h02, 8'h00, 8'h00, 1'b0);
    drain_pipeline();
  endtask

  // Negative with the reset maximum, then a channel above the maximum, then zero
  task automatic test_negative();
    write_reg(CFG_EFFECT_MODE, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
    drain_pipeline();
    write_reg(CFG_MAX_VALUE, 8'd100);
    send_pixel(8'd100, 8'd101, 8'd99, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'd100, 1'b0);
    drain_pipeline();
    write_reg(CFG_MAX_VALUE, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h01, 1'b0);
    drain_pipeline();
  endtask

  // Sepia, selected with spare data bits set; white must clamp
  task automatic test_sepia();
    write_reg(CFG_EFFECT_MODE, 8'hFE);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_xray();
    write_reg(CFG_EFFECT_MODE, 8'h03);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    drain_pipeline();
  endtask

  // Writes to unmapped indexes must leave both registers alone
  task automatic test_unmapped_index();
    write_reg(CFG_UNMAPPED_LO, 8'h00);
    write_reg(CFG_UNMAPPED_HI, 8'h00);
    send_pixel(8'h10, 8'hC0, 8'h7F, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'h33, 1'b1);
    drain_pipeline();
    write_reg(CFG_EFFECT_MODE, 8'hFD);
    send_pixel(8'hFF, 8'hFF, 8'h01, 1'b0);
    drain_pipeline();
  endtask

  // Phases over every mode and several maxima, with varied idling
  task automatic test_random_effects();
    logic [CFG_DATA_BITS-1:0] mode_data;
    logic [CFG_DATA_BITS-1:0] max_data;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_idle_on = (phase % 3) != 0;
      rx_idle_on = (phase % 3) == 1 || (phase % 6) == 2;
      case (phase / 4)
        0:       max_data = 8'h00;
        1:       max_data = 8'hFF;
        default: max_data = CFG_DATA_BITS'($urandom_range(0, 255));
      endcase
      mode_data      = CFG_DATA_BITS'($urandom_range(0, 255));
      mode_data[1:0] = 2'(phase % 4);
      write_reg(CFG_MAX_VALUE, max_data);
      write_reg(CFG_EFFECT_MODE, mode_data);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
                  CFG_DATA_BITS'($urandom_range(0, 255)));
      for (int n = 0; n < PHASE_PIXELS; n++)
        send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 7) == 0);
      drain_pipeline();
    end
  endtask

  // Hold the output off for a long stretch while pixels keep coming
  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CFG_EFFECT_MODE, CFG_DATA_BITS'($urandom_range(0, 255)));
    sink_hold_req = 1'b1;
    for (int n = 0; n < STALL_PIXELS; n++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 3) == 0);
    drain_pipeline();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Output side: random stalls, or one long hold on request
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = rx_idle_on ? pick_gap() : 0;
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare each output beat with the oldest owed pixel
  always @(posedge clk) begin : check_pixel
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel: r=%0d g=%0d b=%0d eoi=%0b",
                   red_out, green_out, blue_out, end_of_image_out);
      end else begin
        want = pending_pixels.pop_front();
        if (red_out !== want.red || green_out !== want.green ||
            blue_out !== want.blue || end_of_image_out !== want.eoi) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display(
              "pixel mismatch: exp r=%0d g=%0d b=%0d eoi=%0b, got r=%0d g=%0d b=%0d eoi=%0b",
              want.red, want.green, want.blue, want.eoi,
              red_out, green_out, blue_out, end_of_image_out);
        end
      end
    end
  end

  // End the run once nothing has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    red_in        = '0;
    green_in      = '0;
    blue_in       = '0;
    end_of_image  = 1'b0;
    mismatches    = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    sink_hold_req = 1'b0;
    mode_mirror   = MODE_GRAY;
    max_mirror    = 8'hFF;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_negative();
    test_sepia();
    test_xray();
    test_unmapped_index();
    test_random_effects();
    test_output_stall();

    drain_pipeline();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
